>>> sv/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg: shared types and constants of the sleep time regulator
// Fixed point widths, saturation helper, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned FIELD_W    = 31;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned OP_W       = 33;
  localparam int unsigned ACC_W      = 2 * OP_W;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [IDX_W-1:0] REG_BAND   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_KI     = 3'd3;
  localparam logic [IDX_W-1:0] REG_KD     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SMIN   = 3'd6;
  localparam logic [IDX_W-1:0] REG_SMAX   = 3'd7;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'h1_0000;
  localparam logic [FIELD_W-1:0] SMAX_RST  = {FIELD_W{1'b1}};

  localparam logic signed [Q_W-1:0]   Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_WAIT,
    ST_SM1,
    ST_SM2,
    ST_SM3,
    ST_P,
    ST_D,
    ST_I1,
    ST_I2,
    ST_I3,
    ST_I4,
    ST_C1,
    ST_C2,
    ST_OUT
  } psr_state_e;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = Q_MAX;
    end else if (v < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/psr_mul.sv
// ----------------------------------------------------------------------------
// psr_mul: shared signed multiplier
// One 33 x 33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module psr_mul (
  input  logic                               clk_i,
  input  logic signed [psr_pkg::OP_W-1:0]    a_i,
  input  logic signed [psr_pkg::OP_W-1:0]    b_i,
  output logic signed [psr_pkg::ACC_W-1:0]   prod_o
);
  import psr_pkg::*;

  logic signed [ACC_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> sv/psr_div.sv
// ----------------------------------------------------------------------------
// psr_div: iterative signed divider
// Computes sat32(num * 2^FRAC_BITS / den), truncated toward zero, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module psr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [psr_pkg::OP_W-1:0]  num_i,
  input  logic signed [psr_pkg::Q_W-1:0]   den_i,
  output logic                             done_o,
  output logic signed [psr_pkg::Q_W-1:0]   quo_o
);
  import psr_pkg::*;

  localparam int unsigned DW    = OP_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_q, dvd_d;
  logic [Q_W-1:0]   rem_q, rem_d;
  logic [Q_W-1:0]   dmag_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [OP_W-1:0]  nmag;
  logic [Q_W-1:0]   dmag;
  logic [Q_W:0]     rem_sh;
  logic [Q_W:0]     rem_sub;
  logic             ge;
  logic             ovf;

  assign nmag    = num_i[OP_W-1] ? OP_W'(-num_i) : OP_W'(num_i);
  assign dmag    = den_i[Q_W-1] ? Q_W'(-den_i) : Q_W'(den_i);
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dmag_q};
  assign ge      = (rem_sh >= {1'b0, dmag_q});
  assign rem_d   = ge ? rem_sub[Q_W-1:0] : rem_sh[Q_W-1:0];
  assign dvd_d   = {dvd_q[DW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {nmag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      dmag_q <= dmag;
      neg_q  <= num_i[OP_W-1] ^ den_i[Q_W-1];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    if (neg_q) begin
      ovf   = (|dvd_q[DW-1:Q_W]) || (dvd_q[Q_W-1] && (|dvd_q[Q_W-2:0]));
      quo_o = ovf ? Q_MIN : -$signed(dvd_q[Q_W-1:0]);
    end else begin
      ovf   = |dvd_q[DW-1:Q_W-1];
      quo_o = ovf ? Q_MAX : $signed(dvd_q[Q_W-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

>>> sv/pid_sleep_time_regulator.sv
// ----------------------------------------------------------------------------
// pid_sleep_time_regulator: PID sleep time regulator with anti-windup
// Each input word passes the error step, the bit-serial divider of the
//   derivative (skipped when the elapsed time is zero), smoothing, PID terms,
//   conditional integration and clamping. No new word is taken until the last
//   result is in the output register. A word with zero now_time yields nothing.
// Reset: asynchronous, active low; clears configuration, controller state and output valid.
// ----------------------------------------------------------------------------
module pid_sleep_time_regulator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: occupancy [30:0], now_time [61:31], zero [63:62]
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [psr_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  // tdata: sleep_time [30:0], zero [31]
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [psr_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // tuser: integral_cleared [0]
  output logic                                 m_axis_tuser_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [psr_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [psr_pkg::FIELD_W-1:0]          cfg_data_i
);
  import psr_pkg::*;

  localparam logic signed [OP_W-1:0] Q_ONE = {{(OP_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  function automatic logic signed [Q_W-1:0] qm(input logic signed [ACC_W-1:0] p);
    return sat_q(p >>> FRAC_BITS);
  endfunction

  psr_state_e state_q, state_d;

  logic [FIELD_W-1:0] target_q, band_q, kp_q, ki_q, kd_q, smin_q, smax_q;
  logic [ALPHA_W-1:0] alpha_q;

  logic signed [Q_W-1:0] isum_q, perr_q, pderiv_q;
  logic [FIELD_W-1:0]    ptime_q, sleep_q;

  logic [FIELD_W-1:0]      occ_q, now_q;
  logic signed [Q_W-1:0]   err_q, dt_q, dv_q, smooth_q, t_q, ctl1_q;
  logic signed [Q_W-1:0]   try_int_q, try_ctl_q, ctl_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    cleared_q;

  logic               out_valid_q;
  logic [FIELD_W-1:0] out_sleep_q;
  logic               out_cleared_q;

  logic                    in_fire, out_free;
  logic [FIELD_W-1:0]      in_occ, in_now;
  logic signed [OP_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0] prod;
  logic                    div_start, div_done;
  logic signed [Q_W-1:0]   div_quo;
  logic signed [OP_W-1:0]  div_num;
  logic signed [OP_W-1:0]  alpha_ext, alpha_c, one_minus;
  logic [Q_W-1:0]          err_mag;
  logic                    cleared_c;
  logic signed [Q_W-1:0]   trial_sleep;
  logic signed [OP_W-1:0]  nxt;
  logic [FIELD_W-1:0]      nxt_clamp;

  assign in_occ   = s_axis_tdata_i[FIELD_W-1:0];
  assign in_now   = s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign alpha_ext = $signed({{(OP_W-ALPHA_W){1'b0}}, alpha_q});
  assign alpha_c   = (alpha_ext > Q_ONE) ? Q_ONE : alpha_ext;
  assign one_minus = Q_ONE - alpha_c;
  assign div_num   = $signed({err_q[Q_W-1], err_q}) - $signed({perr_q[Q_W-1], perr_q});

  assign err_mag     = err_q[Q_W-1] ? Q_W'(-err_q) : Q_W'(err_q);
  assign cleared_c   = (err_mag < {1'b0, band_q});
  assign trial_sleep = sat_q(ACC_W'($signed({1'b0, sleep_q})) - ACC_W'(try_ctl_q));

  assign nxt = $signed({2'b0, sleep_q}) - $signed({ctl_q[Q_W-1], ctl_q});
  always_comb begin
    if (nxt < $signed({2'b0, smin_q})) begin
      nxt_clamp = smin_q;
    end else if (nxt > $signed({2'b0, smax_q})) begin
      nxt_clamp = smax_q;
    end else begin
      nxt_clamp = nxt[FIELD_W-1:0];
    end
  end

  psr_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  psr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_now != '0)) state_d = ST_ERR;
      end
      ST_ERR:  state_d = ST_DIV;
      ST_DIV:  state_d = (dt_q == '0) ? ST_SM1 : ST_WAIT;
      ST_WAIT: begin
        if (div_done) state_d = ST_SM1;
      end
      ST_SM1:  state_d = ST_SM2;
      ST_SM2:  state_d = ST_SM3;
      ST_SM3:  state_d = ST_P;
      ST_P:    state_d = ST_D;
      ST_D:    state_d = ST_I1;
      ST_I1:   state_d = ST_I2;
      ST_I2:   state_d = ST_I3;
      ST_I3:   state_d = ST_I4;
      ST_I4:   state_d = ST_C1;
      ST_C1:   state_d = ST_C2;
      ST_C2:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_DIV:  div_start = (dt_q != '0);
      ST_SM1: begin
        mul_a = one_minus;
        mul_b = OP_W'(pderiv_q);
      end
      ST_SM2: begin
        mul_a = alpha_c;
        mul_b = OP_W'(dv_q);
      end
      ST_SM3: begin
        mul_a = $signed({2'b0, kp_q});
        mul_b = OP_W'(err_q);
      end
      ST_P: begin
        mul_a = $signed({2'b0, kd_q});
        mul_b = OP_W'(smooth_q);
      end
      ST_D: begin
        mul_a = OP_W'(err_q);
        mul_b = OP_W'(dt_q);
      end
      ST_I2: begin
        mul_a = OP_W'(try_int_q);
        mul_b = $signed({2'b0, ki_q});
      end
      ST_C1: begin
        mul_a = OP_W'(isum_q);
        mul_b = $signed({2'b0, ki_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      band_q      <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      alpha_q     <= ALPHA_RST;
      smin_q      <= '0;
      smax_q      <= SMAX_RST;
      isum_q      <= '0;
      perr_q      <= '0;
      pderiv_q    <= '0;
      ptime_q     <= '0;
      sleep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TARGET: target_q <= cfg_data_i;
          REG_BAND:   band_q   <= cfg_data_i;
          REG_KP:     kp_q     <= cfg_data_i;
          REG_KI:     ki_q     <= cfg_data_i;
          REG_KD:     kd_q     <= cfg_data_i;
          REG_ALPHA:  alpha_q  <= cfg_data_i[ALPHA_W-1:0];
          REG_SMIN:   smin_q   <= cfg_data_i;
          REG_SMAX:   smax_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_I4) begin
        if (cleared_c) begin
          isum_q <= '0;
        end else if ((trial_sleep > $signed({1'b0, smin_q})) &&
                     (trial_sleep < $signed({1'b0, smax_q}))) begin
          isum_q <= try_int_q;
        end
      end
      if ((state_q == ST_OUT) && out_free) begin
        sleep_q     <= nxt_clamp;
        perr_q      <= err_q;
        pderiv_q    <= smooth_q;
        ptime_q     <= now_q;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          occ_q <= in_occ;
          now_q <= in_now;
        end
      end
      ST_ERR: begin
        err_q <= sat_q(ACC_W'($signed({2'b0, occ_q}) - $signed({2'b0, target_q})));
        dt_q  <= sat_q(ACC_W'($signed({2'b0, now_q}) - $signed({2'b0, ptime_q})));
      end
      ST_DIV: begin
        if (dt_q == '0) dv_q <= '0;
      end
      ST_WAIT: begin
        if (div_done) dv_q <= div_quo;
      end
      ST_SM2:  acc_q     <= prod;
      ST_SM3:  smooth_q  <= sat_q((acc_q + prod) >>> FRAC_BITS);
      ST_P:    t_q       <= qm(prod);
      ST_D:    ctl1_q    <= sat_q(ACC_W'(t_q) + ACC_W'(qm(prod)));
      ST_I1:   try_int_q <= sat_q(ACC_W'(isum_q) + ACC_W'(qm(prod)));
      ST_I3:   try_ctl_q <= sat_q(ACC_W'(ctl1_q) + ACC_W'(qm(prod)));
      ST_I4:   cleared_q <= cleared_c;
      ST_C2:   ctl_q     <= sat_q(ACC_W'(ctl1_q) + ACC_W'(qm(prod)));
      ST_OUT: begin
        if (out_free) begin
          out_sleep_q   <= nxt_clamp;
          out_cleared_q <= cleared_q;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_sleep_q};
  assign m_axis_tuser_o  = out_cleared_q;

  a_wait_needs_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |-> dt_q != '0)
    else $error("divider wait entered with zero elapsed time");

  a_band_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_I4 && cleared_c) |=> isum_q == '0)
    else $error("integral not cleared inside dead band");

  a_sleep_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free && smin_q <= smax_q) |=>
      (sleep_q >= $past(smin_q) && sleep_q <= $past(smax_q)))
    else $error("sleep time outside clamp limits");

endmodule

>>> tb/sv/pid_sleep_time_regulator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_sleep_time_regulator_test: self-checking bench of the sleep regulator
// Streams occupancy/time words through the regulator under several register
// settings and handshake patterns. A Q16.16 model of the PID step with
// conditional integration predicts every sleep word, and a monitor compares
// each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_sleep_time_regulator_test;
  import psr_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 6;
  localparam int          FRAC          = FRAC_BITS;
  localparam longint      Q1            = 64'sd1 <<< FRAC;
  localparam longint      INT32_HI      = 64'sd2147483647;
  localparam longint      INT32_LO      = -64'sd2147483648;
  localparam logic [30:0] FIELD_ONES    = {FIELD_W{1'b1}};
  localparam int          SETTLE_CYCLES = 80;
  localparam int          HOLD_CYCLES   = 700;
  localparam int          CYCLE_LIMIT   = 1000000;

  typedef logic [FIELD_W-1:0] reg_file_t [8];

  typedef struct packed {
    logic [FIELD_W-1:0] sleep_time;
    logic               integral_cleared;
  } sleep_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_index_i     = '0;
  logic [FIELD_W-1:0]    cfg_data_i      = '0;

  // controller model state
  reg_file_t     shadow_regs;
  longint        ctl_integral;
  longint        last_error;
  longint        last_deriv;
  longint        last_time;
  longint        held_sleep;

  sleep_result_t expected_sleep[$];
  int            mismatch_cnt  = 0;
  int            words_seen    = 0;
  int            cycle_cnt     = 0;
  int unsigned   src_idle_pct  = 0;
  int unsigned   snk_idle_pct  = 0;
  int unsigned   hold_requests = 0;

  pid_sleep_time_regulator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint clip32(input longint v);
    if (v > INT32_HI) return INT32_HI;
    if (v < INT32_LO) return INT32_LO;
    return v;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    return clip32((a * b) >>> FRAC);
  endfunction

  function automatic logic [30:0] qv(input int unsigned whole);
    return 31'(whole << FRAC);
  endfunction

  function automatic void reset_controller_model();
    shadow_regs[REG_TARGET] = '0;
    shadow_regs[REG_BAND]   = '0;
    shadow_regs[REG_KP]     = '0;
    shadow_regs[REG_KI]     = '0;
    shadow_regs[REG_KD]     = '0;
    shadow_regs[REG_ALPHA]  = 31'(ALPHA_RST);
    shadow_regs[REG_SMIN]   = '0;
    shadow_regs[REG_SMAX]   = SMAX_RST;
    ctl_integral = 0;
    last_error   = 0;
    last_deriv   = 0;
    last_time    = 0;
    held_sleep   = 0;
  endfunction

  function automatic bit predict_sleep_step(input logic [30:0] occ_in,
                                            input logic [30:0] now_in,
                                            output sleep_result_t res);
    longint occ, now, target, band, kp, ki, kd, alpha, smin, smax;
    longint err, dt, dv, smooth, ctl1, ctl, mag, next_sleep;
    longint try_int, try_ctl, trial_sleep;
    bit     cleared;
    res    = '0;
    occ    = longint'(occ_in);
    now    = longint'(now_in);
    if (now == 0) return 1'b0;
    target = longint'(shadow_regs[REG_TARGET]);
    band   = longint'(shadow_regs[REG_BAND]);
    kp     = longint'(shadow_regs[REG_KP]);
    ki     = longint'(shadow_regs[REG_KI]);
    kd     = longint'(shadow_regs[REG_KD]);
    alpha  = longint'(shadow_regs[REG_ALPHA][ALPHA_W-1:0]);
    smin   = longint'(shadow_regs[REG_SMIN]);
    smax   = longint'(shadow_regs[REG_SMAX]);
    if (alpha > Q1) alpha = Q1;

    err    = clip32(occ - target);
    dt     = clip32(now - last_time);
    dv     = (dt == 0) ? 0 : clip32(((err - last_error) * Q1) / dt);
    smooth = clip32(((Q1 - alpha) * last_deriv + alpha * dv) >>> FRAC);
    ctl1   = clip32(q_mul(kp, err) + q_mul(kd, smooth));

    mag     = (err < 0) ? -err : err;
    cleared = mag < band;
    if (cleared) begin
      ctl_integral = 0;
    end else begin
      try_int     = clip32(ctl_integral + q_mul(err, dt));
      try_ctl     = clip32(ctl1 + q_mul(try_int, ki));
      trial_sleep = clip32(held_sleep - try_ctl);
      if (trial_sleep > smin && trial_sleep < smax) ctl_integral = try_int;
    end

    ctl        = clip32(ctl1 + q_mul(ctl_integral, ki));
    next_sleep = held_sleep - ctl;
    if (next_sleep < smin) next_sleep = smin;
    else if (next_sleep > smax) next_sleep = smax;
    held_sleep = next_sleep;
    last_error = err;
    last_deriv = smooth;
    last_time  = now;

    res.sleep_time       = next_sleep[30:0];
    res.integral_cleared = cleared;
    return 1'b1;
  endfunction

  task automatic send_sample(input logic [30:0] occ, input logic [30:0] now);
    sleep_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, now, occ};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_sleep_step(occ, now, r)) expected_sleep.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_sleep.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(input reg_file_t words);
    int i;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= IDX_W'(i);
      cfg_data_i  <= words[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      shadow_regs[i] = words[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_regs(output reg_file_t r);
    int unsigned kind;
    int          i;
    kind = $urandom_range(9);
    if (kind == 0) begin
      for (i = 0; i < 8; i++) r[i] = 31'($urandom);
    end else if (kind == 1) begin
      for (i = 0; i < 8; i++) r[i] = $urandom_range(1) ? FIELD_ONES : '0;
    end else begin
      r[REG_TARGET] = 31'($urandom_range(0, 200 << 16));
      r[REG_BAND]   = 31'($urandom_range(0, 4 << 16));
      r[REG_KP]     = 31'($urandom_range(0, 2 << 16));
      r[REG_KI]     = 31'($urandom_range(0, 1 << 16));
      r[REG_KD]     = 31'($urandom_range(0, 1 << 16));
      r[REG_ALPHA]  = 31'($urandom_range(0, (1 << 16) + 4096));
      r[REG_SMIN]   = 31'($urandom_range(0, 4 << 16));
      r[REG_SMAX]   = r[REG_SMIN] + 31'($urandom_range(8 << 16, 400 << 16));
    end
  endtask

  task automatic pick_sample(output logic [30:0] occ, output logic [30:0] now);
    int unsigned kind;
    longint      o, t;
    kind = $urandom_range(99);
    if (kind < 80) begin
      o = longint'(shadow_regs[REG_TARGET]) + longint'($urandom_range(0, 16 << 16))
          - longint'(8 << 16);
      if (o < 0) o = 0;
      if (o > longint'(FIELD_ONES)) o = longint'(FIELD_ONES);
      if ($urandom_range(9) == 0) t = last_time + $urandom_range(1, 16);
      else t = last_time + $urandom_range(1, 3 << 16);
      if (t > longint'(FIELD_ONES)) t = $urandom_range(1, 1 << 16);
      occ = o[30:0];
      now = t[30:0];
    end else if (kind < 88) begin
      occ = 31'($urandom);
      now = 31'($urandom);
    end else if (kind < 93) begin
      occ = 31'($urandom);
      now = '0;
    end else if (kind < 97) begin
      occ = 31'($urandom_range(0, 300 << 16));
      now = last_time[30:0];
    end else begin
      occ = 31'($urandom_range(0, 300 << 16));
      now = (last_time > 1) ? 31'($urandom_range(1, int'(last_time) - 1)) : 31'd1;
    end
  endtask

  // controller starts from reset registers: all gains zero
  task automatic test_reset_state();
    send_sample(qv(5), qv(1));
    send_sample('0, '0);
    send_sample(FIELD_ONES, qv(2));
    send_sample(qv(3), qv(3));
  endtask

  task automatic test_directed_cases();
    reg_file_t r;
    r[REG_TARGET] = qv(10);
    r[REG_BAND]   = qv(1);
    r[REG_KP]     = 31'd32768;
    r[REG_KI]     = 31'd8192;
    r[REG_KD]     = 31'd16384;
    r[REG_ALPHA]  = 31'd32768;
    r[REG_SMIN]   = qv(1);
    r[REG_SMAX]   = qv(100);
    load_regs(r);
    send_sample('0, qv(4));
    send_sample(FIELD_ONES, qv(5));
    send_sample(qv(7), '0);
    send_sample(qv(12), qv(5));
    send_sample(qv(10), qv(4) + 31'd32768);
    send_sample(qv(10) + 31'd32768, qv(6));
    send_sample(qv(11), qv(7));
    send_sample(qv(9), FIELD_ONES);
    send_sample(qv(8), 31'd1);

    // saturating extremes, alpha above one
    r[REG_TARGET] = FIELD_ONES;
    r[REG_BAND]   = '0;
    r[REG_KP]     = FIELD_ONES;
    r[REG_KI]     = FIELD_ONES;
    r[REG_KD]     = FIELD_ONES;
    r[REG_ALPHA]  = FIELD_ONES;
    r[REG_SMIN]   = '0;
    r[REG_SMAX]   = FIELD_ONES;
    load_regs(r);
    send_sample('0, 31'd1);
    send_sample(FIELD_ONES, FIELD_ONES);
    send_sample('0, 31'd2);
    send_sample(FIELD_ONES, 31'd3);

    // lower limit above upper limit
    r[REG_TARGET] = qv(20);
    r[REG_BAND]   = '0;
    r[REG_KP]     = qv(1);
    r[REG_KI]     = 31'd16384;
    r[REG_KD]     = 31'd16384;
    r[REG_ALPHA]  = '0;
    r[REG_SMIN]   = qv(50);
    r[REG_SMAX]   = qv(20);
    load_regs(r);
    send_sample(qv(25), qv(10));
    send_sample(qv(15), qv(11));
    send_sample(qv(20), qv(12));

    r[REG_TARGET] = '0;
    r[REG_KP]     = '0;
    r[REG_KI]     = '0;
    r[REG_KD]     = '0;
    r[REG_SMIN]   = '0;
    r[REG_SMAX]   = '0;
    load_regs(r);
    send_sample(qv(3), qv(13));
    send_sample(FIELD_ONES, qv(14));
  endtask

  task automatic test_random_traffic(input int n_items, input int unsigned src_pct,
                                     input int unsigned snk_pct);
    reg_file_t   r;
    logic [30:0] occ, now;
    int          counted;
    int          batch_left;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    counted      = 0;
    batch_left   = 0;
    while (counted < n_items) begin
      if (batch_left == 0) begin
        pick_regs(r);
        load_regs(r);
        batch_left = $urandom_range(20, 50);
      end
      pick_sample(occ, now);
      send_sample(occ, now);
      if (now != '0) counted++;
      batch_left--;
    end
  endtask

  // hold the output long enough for the input to stall behind it
  task automatic test_output_stall();
    logic [30:0] occ, now;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (8) begin
      pick_sample(occ, now);
      send_sample(occ, now);
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    logic [30:0] occ, now;
    src_idle_pct = 14;
    snk_idle_pct = 14;
    repeat (6) begin
      pick_sample(occ, now);
      send_sample(occ, now);
    end
    wait_drained();
    repeat (6) begin
      pick_sample(occ, now);
      send_sample(occ, now);
    end
  endtask

  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left       = 0;
    holds_served    = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : sleep_monitor
    sleep_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      words_seen++;
      if (expected_sleep.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("word %0d: unexpected sleep %h cleared %b", words_seen,
                   m_axis_tdata_o, m_axis_tuser_o);
        mismatch_cnt++;
      end else begin
        want = expected_sleep.pop_front();
        if (m_axis_tdata_o !== {1'b0, want.sleep_time} ||
            m_axis_tuser_o !== want.integral_cleared) begin
          if (mismatch_cnt < 10)
            $display("word %0d: expected sleep %h cleared %b, got sleep %h cleared %b",
                     words_seen, {1'b0, want.sleep_time}, want.integral_cleared,
                     m_axis_tdata_o, m_axis_tuser_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_controller_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_cases();
    test_random_traffic(200, 14, 53);
    test_random_traffic(200, 53, 14);
    test_random_traffic(200, 0, 0);
    test_output_stall();
    test_drain_pause();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_sleep.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/psr_pkg.sv
sv/psr_mul.sv
sv/psr_div.sv
sv/pid_sleep_time_regulator.sv
tb/sv/pid_sleep_time_regulator_test.sv
